/* hdl/fla_pkg.sv */
package fla_pkg;

    // Default sizing
    localparam int DEF_MAX_FREE_SEGMENTS = 64;
    localparam int DEF_MAX_ALLOCATIONS   = 64;
    localparam int DEF_HEADER_BYTES      = 16;
    localparam int DEF_USER_OFFSET       = 8;

    // Pool register
    localparam logic [16:0] POOL_RESET = 17'd4096;
    localparam logic [16:0] POOL_MAX   = 17'd65536;

    // Request codes
    localparam logic       REQ_ALLOC  = 1'b0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOFIT    = 2'd1;
    localparam logic [1:0] STAT_NOTALLOC = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASCAN,
        ST_AAPPLY,
        ST_FUSCAN,
        ST_FFSCAN,
        ST_FAPPLY,
        ST_SHIFT,
        ST_DONE
    } fla_state_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] alloc_size;
        logic [1:0]  fit_policy;
        logic [15:0] block_addr;
    } fla_req_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [1:0]  status;
    } fla_rsp_t;

    // Pool init values handed to the engine
    typedef struct packed {
        logic        restart;
        logic        seg_ok;
        logic [15:0] seg_size;
    } fla_init_t;

endpackage

/* hdl/fla_engine.sv */
module fla_engine
    import fla_pkg::*;
#(
    parameter int MAX_FREE_SEGMENTS = DEF_MAX_FREE_SEGMENTS,
    parameter int MAX_ALLOCATIONS   = DEF_MAX_ALLOCATIONS,
    parameter int HEADER_BYTES      = DEF_HEADER_BYTES,
    parameter int USER_OFFSET       = DEF_USER_OFFSET
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  fla_init_t init,
    input  logic      req_accept,
    input  fla_req_t  req,
    output logic      idle,
    output logic      rsp_valid,
    input  logic      rsp_take,
    output fla_rsp_t  rsp
);

    localparam int NF   = MAX_FREE_SEGMENTS;
    localparam int NA   = MAX_ALLOCATIONS;
    localparam int FIW  = $clog2(NF);
    localparam int CW   = $clog2(NF + 1);
    localparam int AIW  = (NA > 1) ? $clog2(NA) : 1;
    localparam int MAXN = (NF > NA) ? NF : NA;
    localparam int PW   = $clog2(MAXN + 2);

    localparam logic [16:0]  HDR17 = 17'(HEADER_BYTES);
    localparam logic [17:0]  HDR18 = 18'(HEADER_BYTES);
    localparam logic [15:0]  UOFS  = 16'(USER_OFFSET);
    localparam logic [PW-1:0] NA_P = PW'(NA);

    // Memories: free table {start, size}, allocation table {valid, start, size}
    logic [31:0] free_mem [NF];
    logic [32:0] used_mem [NA];

    logic [FIW-1:0] f_raddr, f_waddr;
    logic [31:0]    f_rdata, f_wdata;
    logic           f_we;
    logic [AIW-1:0] u_raddr, u_waddr;
    logic [32:0]    u_rdata, u_wdata;
    logic           u_we;

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            free_mem[f_waddr] <= f_wdata;
        end
        f_rdata <= free_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            used_mem[u_waddr] <= u_wdata;
        end
        u_rdata <= used_mem[u_raddr];
    end

    // Control and working registers
    fla_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  idx_reg, idx_next;
    logic           fv_reg, fv_next;
    logic           uv_reg, uv_next;
    logic           found_reg, found_next;
    logic [FIW-1:0] k_reg, k_next;
    logic [15:0]    best_reg, best_next;
    logic [15:0]    kst_reg, kst_next;
    logic           ufound_reg, ufound_next;
    logic [AIW-1:0] u_reg, u_next;
    logic [15:0]    ust_reg, ust_next;
    logic [15:0]    usz_reg, usz_next;
    logic           prev_ok_reg, prev_ok_next;
    logic [31:0]    prev_reg, prev_next;
    logic [FIW-1:0] prev_idx_reg, prev_idx_next;
    logic           ifound_reg, ifound_next;
    logic [FIW-1:0] i_reg, i_next;
    logic [31:0]    cur_reg, cur_next;
    logic           up_reg, up_next;
    logic [FIW-1:0] rd_reg, rd_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic           pend_reg, pend_next;
    logic [FIW-1:0] pend_addr_reg, pend_addr_next;
    logic [AIW-1:0] clr_reg, clr_next;
    fla_req_t       req_reg, req_next;
    fla_rsp_t       rsp_reg, rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            fv_reg        <= 1'b0;
            uv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            ufound_reg    <= 1'b0;
            prev_ok_reg   <= 1'b0;
            ifound_reg    <= 1'b0;
            up_reg        <= 1'b0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            fv_reg        <= fv_next;
            uv_reg        <= uv_next;
            found_reg     <= found_next;
            ufound_reg    <= ufound_next;
            prev_ok_reg   <= prev_ok_next;
            ifound_reg    <= ifound_next;
            up_reg        <= up_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        best_reg      <= best_next;
        kst_reg       <= kst_next;
        u_reg         <= u_next;
        ust_reg       <= ust_next;
        usz_reg       <= usz_next;
        prev_reg      <= prev_next;
        prev_idx_reg  <= prev_idx_next;
        i_reg         <= i_next;
        cur_reg       <= cur_next;
        rd_reg        <= rd_next;
        pend_addr_reg <= pend_addr_next;
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
    end

    // Datapath terms
    logic [16:0]   need;
    logic [PW-1:0] count_p, lim;
    logic [15:0]   rd_sz, rd_st;
    logic          fits, better;
    logic [17:0]   b18, end18, prev_end18, merge_both;
    logic          pm, nm;
    logic [FIW-1:0] i_eff;

    always_comb
    begin
        need     = {1'b0, req_reg.alloc_size} + HDR17;
        count_p  = PW'(count_reg);
        lim      = (count_p > NA_P) ? count_p : NA_P;
        rd_sz    = f_rdata[15:0];
        rd_st    = f_rdata[31:16];
        fits     = ({1'b0, rd_sz} >= need);
        better   = !found_reg
                   || ((req_reg.fit_policy == POL_BEST) && (rd_sz < best_reg))
                   || ((req_reg.fit_policy == POL_WORST) && (rd_sz > best_reg));
        b18        = {2'b00, ust_reg};
        end18      = b18 + HDR18 + {2'b00, usz_reg};
        prev_end18 = {2'b00, prev_reg[31:16]} + HDR18 + {2'b00, prev_reg[15:0]};
        merge_both = {2'b00, prev_reg[15:0]} + HDR18 + HDR18 + {2'b00, usz_reg}
                     + {2'b00, cur_reg[15:0]};
        pm    = prev_ok_reg && (prev_end18 == b18);
        nm    = ifound_reg && ({2'b00, cur_reg[31:16]} == end18);
        i_eff = ifound_reg ? i_reg : FIW'(count_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        idx_next       = ptr_reg;
        fv_next        = 1'b0;
        uv_next        = 1'b0;
        found_next     = found_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        kst_next       = kst_reg;
        ufound_next    = ufound_reg;
        u_next         = u_reg;
        ust_next       = ust_reg;
        usz_next       = usz_reg;
        prev_ok_next   = prev_ok_reg;
        prev_next      = prev_reg;
        prev_idx_next  = prev_idx_reg;
        ifound_next    = ifound_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        up_next        = up_reg;
        rd_next        = rd_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        f_raddr        = ptr_reg[FIW-1:0];
        f_we           = 1'b0;
        f_waddr        = '0;
        f_wdata        = '0;
        u_raddr        = ptr_reg[AIW-1:0];
        u_we           = 1'b0;
        u_waddr        = '0;
        u_wdata        = '0;

        case (state_reg)
            // Drop all allocations; rebuild the single free segment
            ST_CLEAR:
            begin
                u_we    = 1'b1;
                u_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    f_we    = 1'b1;
                    f_waddr = '0;
                    f_wdata = {16'h0000, init.seg_size};
                end
                if (clr_reg == AIW'(NA - 1))
                begin
                    count_next = init.seg_ok ? CW'(1) : '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AIW'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_accept)
                begin
                    req_next     = req;
                    ptr_next     = '0;
                    found_next   = 1'b0;
                    ufound_next  = 1'b0;
                    prev_ok_next = 1'b0;
                    ifound_next  = 1'b0;
                    state_next   = (req.req_type == REQ_ALLOC) ? ST_ASCAN : ST_FUSCAN;
                end
            end

            // Alloc: fit search over free table and free-slot search in parallel
            ST_ASCAN:
            begin
                fv_next = (ptr_reg < count_p);
                uv_next = (ptr_reg < NA_P);
                if (ptr_reg < lim)
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
                if (fv_reg && fits && better)
                begin
                    found_next = 1'b1;
                    k_next     = idx_reg[FIW-1:0];
                    best_next  = rd_sz;
                    kst_next   = rd_st;
                end
                if (uv_reg && !u_rdata[32] && !ufound_reg)
                begin
                    ufound_next = 1'b1;
                    u_next      = idx_reg[AIW-1:0];
                end
                if ((ptr_reg >= lim) && !fv_reg && !uv_reg)
                begin
                    state_next = ST_AAPPLY;
                end
            end

            ST_AAPPLY:
            begin
                rsp_next.result_addr = '0;
                state_next           = ST_DONE;
                if (!found_reg)
                begin
                    rsp_next.status = STAT_NOFIT;
                end
                else if (!ufound_reg)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    u_we    = 1'b1;
                    u_waddr = u_reg;
                    u_wdata = {1'b1, kst_reg, req_reg.alloc_size};
                    rsp_next.status      = STAT_OK;
                    rsp_next.result_addr = kst_reg + UOFS;
                    if ({1'b0, best_reg} == need)
                    begin
                        // exact fit: close the gap
                        up_next    = 1'b0;
                        rd_next    = k_reg + FIW'(1);
                        rem_next   = count_reg - CW'(k_reg) - CW'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        f_we    = 1'b1;
                        f_waddr = k_reg;
                        f_wdata = {kst_reg + need[15:0], best_reg - need[15:0]};
                    end
                end
            end

            // Free: look the address up in the allocation table
            ST_FUSCAN:
            begin
                uv_next = (ptr_reg < NA_P);
                if (ptr_reg < NA_P)
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
                if (uv_reg && u_rdata[32] && !ufound_reg
                    && ((u_rdata[31:16] + UOFS) == req_reg.block_addr))
                begin
                    ufound_next = 1'b1;
                    u_next      = idx_reg[AIW-1:0];
                    ust_next    = u_rdata[31:16];
                    usz_next    = u_rdata[15:0];
                end
                if ((ptr_reg >= NA_P) && !uv_reg)
                begin
                    ptr_next = '0;
                    if (ufound_reg)
                    begin
                        state_next = ST_FFSCAN;
                    end
                    else
                    begin
                        rsp_next.status      = STAT_NOTALLOC;
                        rsp_next.result_addr = '0;
                        state_next           = ST_DONE;
                    end
                end
            end

            // Free: find insertion point and both neighbors
            ST_FFSCAN:
            begin
                fv_next = (ptr_reg < count_p);
                if (ptr_reg < count_p)
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
                if (fv_reg && !ifound_reg)
                begin
                    if (rd_st >= ust_reg)
                    begin
                        ifound_next = 1'b1;
                        i_next      = idx_reg[FIW-1:0];
                        cur_next    = f_rdata;
                    end
                    else
                    begin
                        prev_ok_next  = 1'b1;
                        prev_next     = f_rdata;
                        prev_idx_next = idx_reg[FIW-1:0];
                    end
                end
                if ((ptr_reg >= count_p) && !fv_reg)
                begin
                    state_next = ST_FAPPLY;
                end
            end

            ST_FAPPLY:
            begin
                rsp_next.result_addr = '0;
                rsp_next.status      = STAT_OK;
                state_next           = ST_DONE;
                i_next               = i_eff;
                if (!pm && !nm && (count_reg >= CW'(NF)))
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    u_we    = 1'b1;
                    u_waddr = u_reg;
                    u_wdata = '0;
                    if (pm)
                    begin
                        f_we    = 1'b1;
                        f_waddr = prev_idx_reg;
                        if (nm)
                        begin
                            f_wdata    = {prev_reg[31:16], merge_both[15:0]};
                            up_next    = 1'b0;
                            rd_next    = i_reg + FIW'(1);
                            rem_next   = count_reg - CW'(i_reg) - CW'(1);
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            f_wdata = {prev_reg[31:16],
                                       prev_reg[15:0] + 16'(HEADER_BYTES) + usz_reg};
                        end
                    end
                    else if (nm)
                    begin
                        f_we    = 1'b1;
                        f_waddr = i_reg;
                        f_wdata = {ust_reg, usz_reg + 16'(HEADER_BYTES) + cur_reg[15:0]};
                    end
                    else
                    begin
                        // open a slot at the insertion point
                        up_next    = 1'b1;
                        rd_next    = FIW'(count_reg - CW'(1));
                        rem_next   = count_reg - CW'(i_eff);
                        state_next = ST_SHIFT;
                    end
                end
            end

            // Move a run of free entries by one place, one entry per cycle
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    f_we    = 1'b1;
                    f_waddr = pend_addr_reg;
                    f_wdata = f_rdata;
                end
                if (rem_reg != '0)
                begin
                    f_raddr        = rd_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? (rd_reg + FIW'(1)) : (rd_reg - FIW'(1));
                    rd_next        = up_reg ? (rd_reg - FIW'(1)) : (rd_reg + FIW'(1));
                    rem_next       = rem_reg - CW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                    if (up_reg)
                    begin
                        f_we       = 1'b1;
                        f_waddr    = i_reg;
                        f_wdata    = {ust_reg, usz_reg};
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (rsp_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // Pool write restarts everything
        if (init.restart)
        begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NF))
        else $error("free segment count exceeds table depth");

    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        init.restart |=> (state_reg == ST_CLEAR) && (clr_reg == '0))
        else $error("pool write did not restart clearing");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !rsp_take && !init.restart |=> (state_reg == ST_DONE)
        && $stable(rsp_reg))
        else $error("result dropped before being taken");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && pend_reg && (rem_reg != '0) |-> (f_waddr != f_raddr))
        else $error("shift read and write hit the same entry");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && up_reg |-> (count_reg < CW'(NF)))
        else $error("insert started with a full free table");

endmodule

/* hdl/free_list_allocator.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    req_type, alloc_size, fit_policy, block_addr
// out       output     out_valid / out_ready  result_addr, status
// cfg       input      cfg_wr_en              cfg_wr_data (pool size)
//
// One request at a time. Both scans walk the tables through the single read port of each
// table memory, and removing or inserting a free entry moves the following entries one
// place, one entry at a time. After reset and after each pool write a clearing pass over
// all MAX_ALLOCATIONS allocation entries runs before in_ready rises. A stalled out channel
// holds the next result in the engine, with in_ready low until it is taken.
module free_list_allocator
    import fla_pkg::*;
#(
    parameter int MAX_FREE_SEGMENTS = DEF_MAX_FREE_SEGMENTS,
    parameter int MAX_ALLOCATIONS   = DEF_MAX_ALLOCATIONS,
    parameter int HEADER_BYTES      = DEF_HEADER_BYTES,
    parameter int USER_OFFSET       = DEF_USER_OFFSET
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] alloc_size,
    input  logic [1:0]  fit_policy,
    input  logic [15:0] block_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_addr,
    output logic [1:0]  status,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);

    logic [16:0] pool_reg;
    logic        out_valid_reg;
    fla_rsp_t    out_reg;
    fla_init_t   init;
    fla_req_t    req;
    fla_rsp_t    rsp;
    logic        idle, rsp_valid, rsp_take;

    // Pool size register, saturated on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            pool_reg <= (cfg_wr_data > POOL_MAX) ? POOL_MAX : cfg_wr_data;
        end
    end

    always_comb
    begin
        init.restart  = cfg_wr_en;
        init.seg_ok   = (pool_reg >= HDR17);
        init.seg_size = 16'(pool_reg - HDR17);
        req.req_type   = req_type;
        req.alloc_size = alloc_size;
        req.fit_policy = fit_policy;
        req.block_addr = block_addr;
    end

    assign in_ready = idle;
    assign rsp_take = rsp_valid && (!out_valid_reg || out_ready);

    fla_engine #(
        .MAX_FREE_SEGMENTS (MAX_FREE_SEGMENTS),
        .MAX_ALLOCATIONS   (MAX_ALLOCATIONS),
        .HEADER_BYTES      (HEADER_BYTES),
        .USER_OFFSET       (USER_OFFSET)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (init),
        .req_accept (in_valid && idle),
        .req        (req),
        .idle       (idle),
        .rsp_valid  (rsp_valid),
        .rsp_take   (rsp_take),
        .rsp        (rsp)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_take)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_addr = out_reg.result_addr;
    assign status      = out_reg.status;

endmodule
